// File: hdl/cbm_pkg.sv
// Shared types, constants and helpers for the cartridge bank mapper.
// Used by cbm_core and cartridge_bank_mapper_scanline_irq_top; depends on nothing.
package cbm_pkg;

   // Work RAM size in bytes (1024 to 8192) and the matching address width.
   localparam int unsigned WORK_RAM_BYTES = 8192;
   localparam int unsigned WRAM_AW        = $clog2(WORK_RAM_BYTES);

   // Multiples of the RAM size used by the offset reduction.
   localparam logic [15:0] WRAM_STEP_1 = 16'(WORK_RAM_BYTES);
   localparam logic [15:0] WRAM_STEP_2 = 16'(2 * WORK_RAM_BYTES);
   localparam logic [15:0] WRAM_STEP_4 = 16'(4 * WORK_RAM_BYTES);

   // Request kinds carried on the mode field.
   localparam logic [2:0] MODE_CPU_READ  = 3'd0;
   localparam logic [2:0] MODE_CPU_WRITE = 3'd1;
   localparam logic [2:0] MODE_PPU_READ  = 3'd2;
   localparam logic [2:0] MODE_PPU_WRITE = 3'd3;
   localparam logic [2:0] MODE_SCANLINE  = 3'd4;
   localparam logic [2:0] MODE_IRQ_ACK   = 3'd5;

   // Register groups selected by CPU address bits 14:13.
   localparam logic [1:0] REG_BANK   = 2'd0;
   localparam logic [1:0] REG_MIRROR = 2'd1;
   localparam logic [1:0] REG_RELOAD = 2'd2;
   localparam logic [1:0] REG_IRQ_EN = 2'd3;

   // Reset value of the program ROM size register.
   localparam logic [5:0] PRG_BANKS_RESET = 6'd32;

   // Access to the work RAM issued when a request is accepted.
   typedef struct packed {
      logic               en;
      logic               we;
      logic [WRAM_AW-1:0] addr;
      logic [7:0]         wdata;
   } ram_cmd_type;

   // Result fields except the RAM read data, which the work RAM registers on its own.
   typedef struct packed {
      logic        handled;
      logic        ram_hit;
      logic        ram_read;
      logic [18:0] mapped;
      logic        irq;
      logic        mirror;
   } result_type;

   // Reduce a 13-bit window offset modulo the RAM size. The quotient is
   // below eight, so three restoring compare-and-subtract steps suffice.
   function automatic logic [WRAM_AW-1:0] wram_offset(input logic [12:0] a);
      logic [15:0] r;
      r = {3'b000, a};
      if (r >= WRAM_STEP_4) r = r - WRAM_STEP_4;
      if (r >= WRAM_STEP_2) r = r - WRAM_STEP_2;
      if (r >= WRAM_STEP_1) r = r - WRAM_STEP_1;
      return r[WRAM_AW-1:0];
   endfunction

endpackage

// File: hdl/cbm_core.sv
// Mapper register file, address translation and scanline interrupt counter.
// Depends on cbm_pkg; issues work RAM commands to the top level.
module cbm_core import cbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [2:0]  mode,
   input  logic [15:0] address,
   input  logic [7:0]  write_data,
   input  logic [5:0]  prg_banks,
   output ram_cmd_type ram_cmd,
   output result_type  result
);

   logic [7:0] bank_regs_ff [8];
   logic [7:0] bank_regs_in [8];
   logic [7:0] slot_ff [8];
   logic [7:0] slot_in [8];
   logic [2:0] target_ff, target_in;
   logic       prg_mode_ff, prg_mode_in;
   logic       chr_inv_ff, chr_inv_in;
   logic       applied_ff, applied_in;
   logic [5:0] switch_a_ff, switch_a_in;
   logic [5:0] switch_b_ff, switch_b_in;
   logic       mirror_ff, mirror_in;
   logic [7:0] reload_ff, reload_in;
   logic [7:0] count_ff, count_in;
   logic       irq_en_ff, irq_en_in;
   logic       irq_act_ff, irq_act_in;

   logic       is_cpu, in_ram, in_rom, in_pattern;
   logic [5:0] last_bank, second_bank, prg_bank;
   logic [7:0] pair0, pair2;

   // Address window decode.
   assign is_cpu     = (mode == MODE_CPU_READ) || (mode == MODE_CPU_WRITE);
   assign in_ram     = (address[15:13] == 3'b011);
   assign in_rom     = address[15];
   assign in_pattern = (address[15:13] == 3'b000);

   // Fixed banks are the last two 8K banks, wrapping at 64.
   assign last_bank   = {prg_banks[4:0], 1'b0} - 6'd1;
   assign second_bank = {prg_banks[4:0], 1'b0} - 6'd2;

   // Program slot selection.
   always_comb begin
      case (address[14:13])
         2'd0:    prg_bank = applied_ff ? second_bank : switch_a_ff;
         2'd1:    prg_bank = switch_b_ff;
         2'd2:    prg_bank = applied_ff ? switch_a_ff : second_bank;
         default: prg_bank = last_bank;
      endcase
   end

   // Next state of the register file and the interrupt counter.
   always_comb begin
      bank_regs_in = bank_regs_ff;
      slot_in      = slot_ff;
      target_in    = target_ff;
      prg_mode_in  = prg_mode_ff;
      chr_inv_in   = chr_inv_ff;
      applied_in   = applied_ff;
      switch_a_in  = switch_a_ff;
      switch_b_in  = switch_b_ff;
      mirror_in    = mirror_ff;
      reload_in    = reload_ff;
      count_in     = count_ff;
      irq_en_in    = irq_en_ff;
      irq_act_in   = irq_act_ff;
      pair0        = 8'd0;
      pair2        = 8'd0;
      if (accept) begin
         case (mode)
            MODE_CPU_WRITE: begin
               if (in_rom) begin
                  case (address[14:13])
                     REG_BANK: begin
                        if (!address[0]) begin
                           target_in   = write_data[2:0];
                           prg_mode_in = write_data[6];
                           chr_inv_in  = write_data[7];
                        end else begin
                           // A bank data write also latches the whole mapping.
                           bank_regs_in[target_ff] = write_data;
                           pair0 = {bank_regs_in[0][7:1], 1'b0};
                           pair2 = {bank_regs_in[1][7:1], 1'b0};
                           for (int i = 0; i < 4; i++) begin
                              slot_in[{~chr_inv_ff, 2'(i)}] = bank_regs_in[3'(2 + i)];
                           end
                           slot_in[{chr_inv_ff, 2'd0}] = pair0;
                           slot_in[{chr_inv_ff, 2'd1}] = {pair0[7:1], 1'b1};
                           slot_in[{chr_inv_ff, 2'd2}] = pair2;
                           slot_in[{chr_inv_ff, 2'd3}] = {pair2[7:1], 1'b1};
                           applied_in  = prg_mode_ff;
                           switch_a_in = bank_regs_in[6][5:0];
                           switch_b_in = bank_regs_in[7][5:0];
                        end
                     end
                     REG_MIRROR: begin
                        if (!address[0]) mirror_in = write_data[0];
                     end
                     REG_RELOAD: begin
                        if (!address[0]) reload_in = write_data;
                        else             count_in  = 8'd0;
                     end
                     default: begin
                        if (!address[0]) begin
                           irq_en_in  = 1'b0;
                           irq_act_in = 1'b0;
                        end else begin
                           irq_en_in = 1'b1;
                        end
                     end
                  endcase
               end
            end
            MODE_SCANLINE: begin
               count_in = (count_ff == 8'd0) ? reload_ff : count_ff - 8'd1;
               if ((count_in == 8'd0) && irq_en_ff) irq_act_in = 1'b1;
            end
            MODE_IRQ_ACK: begin
               irq_act_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            bank_regs_ff[3'(i)] <= 8'd0;
            slot_ff[3'(i)]      <= 8'd0;
         end
         target_ff   <= 3'd0;
         prg_mode_ff <= 1'b0;
         chr_inv_ff  <= 1'b0;
         applied_ff  <= 1'b0;
         switch_a_ff <= 6'd0;
         switch_b_ff <= 6'd1;
         mirror_ff   <= 1'b1;
         reload_ff   <= 8'd0;
         count_ff    <= 8'd0;
         irq_en_ff   <= 1'b0;
         irq_act_ff  <= 1'b0;
      end else begin
         bank_regs_ff <= bank_regs_in;
         slot_ff      <= slot_in;
         target_ff    <= target_in;
         prg_mode_ff  <= prg_mode_in;
         chr_inv_ff   <= chr_inv_in;
         applied_ff   <= applied_in;
         switch_a_ff  <= switch_a_in;
         switch_b_ff  <= switch_b_in;
         mirror_ff    <= mirror_in;
         reload_ff    <= reload_in;
         count_ff     <= count_in;
         irq_en_ff    <= irq_en_in;
         irq_act_ff   <= irq_act_in;
      end
   end

   // Work RAM command for CPU accesses inside the RAM window.
   always_comb begin
      ram_cmd.en    = accept && is_cpu && in_ram;
      ram_cmd.we    = (mode == MODE_CPU_WRITE);
      ram_cmd.addr  = wram_offset(address[12:0]);
      ram_cmd.wdata = write_data;
   end

   // Result fields; the interrupt and mirroring flags report the state after the request.
   always_comb begin
      result.handled  = 1'b0;
      result.ram_hit  = 1'b0;
      result.ram_read = 1'b0;
      result.mapped   = 19'd0;
      result.irq      = irq_act_in;
      result.mirror   = mirror_in;
      if (is_cpu && in_ram) begin
         result.handled  = 1'b1;
         result.ram_hit  = 1'b1;
         result.ram_read = (mode == MODE_CPU_READ);
      end else if ((mode == MODE_CPU_READ) && in_rom) begin
         result.handled = 1'b1;
         result.mapped  = {prg_bank, address[12:0]};
      end else if ((mode == MODE_PPU_READ) && in_pattern) begin
         result.handled = 1'b1;
         result.mapped  = {1'b0, slot_ff[address[12:10]], address[9:0]};
      end
   end

endmodule

// File: hdl/cartridge_bank_mapper_scanline_irq_top.sv
// Top level of the cartridge bank mapper: work RAM, output register and
// configuration register. Depends on cbm_pkg and cbm_core.

// The mapper takes one request per clock cycle and returns its result in the
// cycle after acceptance, so a new request may follow in every cycle while
// the output is being taken. The read data comes from the work RAM, a
// synchronous memory read at the acceptance edge. Work RAM contents are
// undefined until written and need no clearing pass: the block is ready
// straight after reset. The program ROM size register is written through
// the csr_ port, which is always ready, and should be changed only while
// no request is in flight.
module cartridge_bank_mapper_scanline_irq_top import cbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_handled,
   output logic        rsp_ram_hit,
   output logic [7:0]  rsp_read_data,
   output logic [18:0] rsp_mapped_address,
   output logic        rsp_irq_pending,
   output logic        rsp_mirror_horizontal,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_prg_rom_16k_banks
);

   logic [7:0]  wram_mem [WORK_RAM_BYTES];
   logic [7:0]  rdata_ff;
   logic        valid_ff, valid_in;
   result_type  res_ff;
   result_type  result;
   ram_cmd_type ram_cmd;
   logic [5:0]  prg_banks_ff, prg_banks_in;
   logic        accept;

   // A request enters whenever the output register is empty or being drained.
   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   cbm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (req_mode),
      .address    (req_address),
      .write_data (req_write_data),
      .prg_banks  (prg_banks_ff),
      .ram_cmd    (ram_cmd),
      .result     (result)
   );

   // Work RAM: one access per accepted CPU request in the RAM window, read data registered.
   always_ff @(posedge clock) begin
      if (ram_cmd.en) begin
         if (ram_cmd.we) begin
            wram_mem[ram_cmd.addr] <= ram_cmd.wdata;
         end else begin
            rdata_ff <= wram_mem[ram_cmd.addr];
         end
      end
   end

   // Configuration register.
   assign prg_banks_in = csr_valid ? csr_prg_rom_16k_banks : prg_banks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_banks_ff <= PRG_BANKS_RESET;
      end else begin
         prg_banks_ff <= prg_banks_in;
      end
   end

   // Output register.
   assign valid_in = accept || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= result;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_handled           = res_ff.handled;
   assign rsp_ram_hit           = res_ff.ram_hit;
   assign rsp_read_data         = res_ff.ram_read ? rdata_ff : 8'd0;
   assign rsp_mapped_address    = res_ff.mapped;
   assign rsp_irq_pending       = res_ff.irq;
   assign rsp_mirror_horizontal = res_ff.mirror;

endmodule
